>>> rtl/core/brflp_pkg.sv
// ----------------------------------------------------------------------------
// brflp_pkg: shared types and constants of the byte ring FIFO with line scan
// Command and status codes, sequencer states, walk unit flags and widths.
// ----------------------------------------------------------------------------
package brflp_pkg;

    localparam int DEPTH_DEF = 2048;
    localparam int DATA_W    = 8;
    localparam int LEN_W     = 12;
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 3;

    localparam logic [DATA_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [DATA_W-1:0] CH_NUL     = 8'h00;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_SCAN   = 3'd2,
        CMD_COMMIT = 3'd3,
        CMD_REWIND = 3'd4,
        CMD_CLEAR  = 3'd5
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_FULL       = 3'd1,
        STAT_EMPTY      = 3'd2,
        STAT_INCOMPLETE = 3'd3,
        STAT_TOOLONG    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_SCAN
    } t_state;

    // Flags of one walk step over the stored bytes.
    typedef struct packed {
        logic at_end;
        logic at_limit;
        logic hit;
    } t_walk;

endpackage

>>> rtl/core/brflp_ram.sv
// ----------------------------------------------------------------------------
// brflp_ram: generic single-port RAM
// One address for write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module brflp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

>>> rtl/core/brflp_walk.sv
// ----------------------------------------------------------------------------
// brflp_walk: shared pointer step and scan compare unit
// Wraps a ring pointer forward and checks end, limit and delimiter.
// ----------------------------------------------------------------------------
module brflp_walk #(
    parameter int DEPTH = brflp_pkg::DEPTH_DEF
) (
    input  logic [$clog2(DEPTH)-1:0]    i_pos,
    input  logic [$clog2(DEPTH)-1:0]    i_wr_ptr,
    input  logic [brflp_pkg::LEN_W-1:0]  i_cnt,
    input  logic [brflp_pkg::LEN_W-1:0]  i_limit,
    input  logic [brflp_pkg::DATA_W-1:0] i_data,
    input  logic [brflp_pkg::DATA_W-1:0] i_delim,
    output logic [$clog2(DEPTH)-1:0]    o_next_pos,
    output brflp_pkg::t_walk            o_walk
);
    import brflp_pkg::*;

    localparam int AW = $clog2(DEPTH);

    // Wrap at the last slot so any depth works, not just powers of two.
    assign o_next_pos = (i_pos == AW'(DEPTH - 1)) ? '0 : i_pos + AW'(1);

    assign o_walk.at_end   = (i_pos == i_wr_ptr);
    assign o_walk.at_limit = (i_cnt >= i_limit);
    assign o_walk.hit      = (i_data == i_delim);

endmodule

>>> rtl/core/byte_ring_fifo_line_peek_top.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_line_peek_top: circular byte FIFO with peek pointer and scan
// Results: push, commit, rewind, clear and unused codes give their result in
//   the cycle after the request; pop reads the RAM and answers from the pop
//   state; a line scan examines bytes in the scan state until the end of data, the limit or a delimiter stops it.
// Throughput: one request at a time; the single RAM port and the walk unit
//   carry one byte per cycle. The receiver cannot stall, results are strobed.
// Reset: synchronous, active low; clears all three pointers and the sequencer.
// ----------------------------------------------------------------------------
module byte_ring_fifo_line_peek_top #(
    parameter int DEPTH = brflp_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [brflp_pkg::CMD_W-1:0]  i_cmd,
    input  logic [brflp_pkg::DATA_W-1:0] i_in_byte,
    input  logic                         i_delim_sel,
    input  logic [brflp_pkg::LEN_W-1:0]  i_max_len,
    output logic                         o_valid,
    output logic [brflp_pkg::DATA_W-1:0] o_out_byte,
    output logic [brflp_pkg::LEN_W-1:0]  o_line_length,
    output logic [brflp_pkg::STAT_W-1:0] o_status,
    output logic [$clog2(DEPTH)-1:0]     o_fill_count,
    output logic [$clog2(DEPTH)-1:0]     o_free_space
);
    import brflp_pkg::*;

    localparam int AW = $clog2(DEPTH);

    // Sequencer and ring pointers
    t_state            r_state, n_state;
    logic [AW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [AW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]     r_pk_ptr, n_pk_ptr;

    // Scan cursor, byte count and latched request fields
    logic [AW-1:0]     r_pos, n_pos;
    logic [LEN_W-1:0]  r_cnt, n_cnt;
    logic [LEN_W-1:0]  r_limit, n_limit;
    logic [DATA_W-1:0] r_delim, n_delim;

    // Result register
    logic              r_valid, n_valid;
    logic [DATA_W-1:0] r_out_byte, n_out_byte;
    logic [LEN_W-1:0]  r_len, n_len;
    t_status           r_status, n_status;
    logic [AW-1:0]     r_fill;
    logic [AW-1:0]     r_free;

    // RAM port
    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [DATA_W-1:0] ram_rdata;

    // Walk unit
    logic [AW-1:0]     walk_pos;
    logic [AW-1:0]     walk_next;
    t_walk             walk;

    logic              accept;
    logic [AW-1:0]     cur_fill;
    logic [AW-1:0]     nxt_fill;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);

    // Fill count: write minus read around the ring.
    function automatic logic [AW-1:0] ring_fill(input logic [AW-1:0] wr,
                                                input logic [AW-1:0] rd);
        logic [AW:0] diff;
        diff = {1'b0, wr} - {1'b0, rd};
        if (wr < rd) begin
            diff = diff + (AW+1)'(DEPTH);
        end
        return diff[AW-1:0];
    endfunction

    assign cur_fill = ring_fill(r_wr_ptr, r_rd_ptr);
    assign nxt_fill = ring_fill(n_wr_ptr, n_rd_ptr);

    brflp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_in_byte),
        .o_rdata (ram_rdata)
    );

    // Share the step unit: write pointer for push, read pointer for pop,
    // scan cursor while scanning.
    always_comb begin
        priority if (r_state == ST_SCAN) begin
            walk_pos = r_pos;
        end else if (r_state == ST_POP) begin
            walk_pos = r_rd_ptr;
        end else begin
            walk_pos = r_wr_ptr;
        end
    end

    brflp_walk #(
        .DEPTH (DEPTH)
    ) u_walk (
        .i_pos      (walk_pos),
        .i_wr_ptr   (r_wr_ptr),
        .i_cnt      (r_cnt),
        .i_limit    (r_limit),
        .i_data     (ram_rdata),
        .i_delim    (r_delim),
        .o_next_pos (walk_next),
        .o_walk     (walk)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_pk_ptr <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_pk_ptr <= n_pk_ptr;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_cnt   <= n_cnt;
        r_limit <= n_limit;
        r_delim <= n_delim;
        if (n_valid) begin
            r_out_byte <= n_out_byte;
            r_len      <= n_len;
            r_status   <= n_status;
            r_fill     <= nxt_fill;
            r_free     <= AW'(DEPTH - 1) - nxt_fill;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_rd_ptr   = r_rd_ptr;
        n_wr_ptr   = r_wr_ptr;
        n_pk_ptr   = r_pk_ptr;
        n_pos      = r_pos;
        n_cnt      = r_cnt;
        n_limit    = r_limit;
        n_delim    = r_delim;
        n_valid    = 1'b0;
        n_out_byte = '0;
        n_len      = '0;
        n_status   = STAT_OK;
        ram_we     = 1'b0;
        ram_addr   = r_wr_ptr;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_cmd'(i_cmd))
                        CMD_PUSH: begin
                            n_valid = 1'b1;
                            // Drop the byte when only the spare slot is left.
                            if (cur_fill == AW'(DEPTH - 1)) begin
                                n_status = STAT_FULL;
                            end else begin
                                ram_we   = 1'b1;
                                n_wr_ptr = walk_next;
                            end
                        end
                        CMD_POP: begin
                            if (cur_fill == '0) begin
                                n_valid  = 1'b1;
                                n_status = STAT_EMPTY;
                            end else begin
                                ram_addr = r_rd_ptr;
                                n_state  = ST_POP;
                            end
                        end
                        CMD_SCAN: begin
                            // Fetch the byte at peek; its data is there next cycle.
                            ram_addr = r_pk_ptr;
                            n_pos    = r_pk_ptr;
                            n_cnt    = '0;
                            n_limit  = i_max_len;
                            n_delim  = i_delim_sel ? CH_NUL : CH_NEWLINE;
                            n_state  = ST_SCAN;
                        end
                        CMD_COMMIT: begin
                            n_valid  = 1'b1;
                            n_rd_ptr = r_pk_ptr;
                        end
                        CMD_REWIND: begin
                            n_valid  = 1'b1;
                            n_pk_ptr = r_rd_ptr;
                        end
                        CMD_CLEAR: begin
                            n_valid  = 1'b1;
                            n_rd_ptr = '0;
                            n_wr_ptr = '0;
                            n_pk_ptr = '0;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP: begin
                n_valid    = 1'b1;
                n_out_byte = ram_rdata;
                n_rd_ptr   = walk_next;
                n_state    = ST_IDLE;
            end
            ST_SCAN: begin
                // Order matters: end of data beats the limit, the limit beats a match.
                priority if (walk.at_end) begin
                    n_valid  = 1'b1;
                    n_status = STAT_INCOMPLETE;
                    n_state  = ST_IDLE;
                end else if (walk.at_limit) begin
                    n_valid  = 1'b1;
                    n_status = STAT_TOOLONG;
                    n_state  = ST_IDLE;
                end else if (walk.hit) begin
                    n_valid  = 1'b1;
                    n_len    = r_cnt + LEN_W'(1);
                    n_pk_ptr = walk_next;
                    n_state  = ST_IDLE;
                end else begin
                    // Advance the cursor and prefetch the following byte.
                    ram_addr = walk_next;
                    n_pos    = walk_next;
                    n_cnt    = r_cnt + LEN_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_valid       = r_valid;
    assign o_out_byte    = r_out_byte;
    assign o_line_length = r_len;
    assign o_status      = r_status;
    assign o_fill_count  = r_fill;
    assign o_free_space  = r_free;

    // No result leaves while a pop or scan is still in flight.
    a_no_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !r_valid)
        else $error("result strobe while sequencer busy");

    // Every accepted request either answers next cycle or holds busy.
    a_request_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (o_valid || busy))
        else $error("accepted request neither answered nor busy");

    // Fill and free space of every result add up to the usable capacity.
    a_fill_free_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (({1'b0, o_fill_count} + {1'b0, o_free_space}) ==
                     (AW+1)'(DEPTH - 1)))
        else $error("fill count and free space disagree");

    // Only a successful scan reports a line length.
    a_len_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != STAT_OK)) |-> (o_line_length == '0))
        else $error("line length on a failed request");

    // Pointers never leave the ring.
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_ptr <= AW'(DEPTH - 1)) && (r_wr_ptr <= AW'(DEPTH - 1)) &&
        (r_pk_ptr <= AW'(DEPTH - 1)))
        else $error("ring pointer out of range");

endmodule
